>>> rtl/track_vertex_impact_parameter_macros.svh
// Assertion helpers shared by the RTL. Each check runs on clk and is off in reset.
`ifndef TRACK_VERTEX_IMPACT_PARAMETER_MACROS_SVH
`define TRACK_VERTEX_IMPACT_PARAMETER_MACROS_SVH

// Same-cycle implication.
`define TVIP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tvip check failed");

// Next-cycle implication.
`define TVIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tvip check failed");

`endif

>>> rtl/tvip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvip_pkg;
	localparam int SLOPE_W     = 20;
	localparam int POS_W       = 24;
	localparam int OUT_W       = 33;
	localparam int SCALE_SHIFT = 16;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope_x;
		logic signed [SLOPE_W-1:0] slope_y;
		logic signed [POS_W-1:0]   track_x;
		logic signed [POS_W-1:0]   track_y;
		logic signed [POS_W-1:0]   track_z;
		logic signed [POS_W-1:0]   vertex_x;
		logic signed [POS_W-1:0]   vertex_y;
		logic signed [POS_W-1:0]   vertex_z;
	} track_beat_t;

	typedef struct packed {
		logic [OUT_W-1:0] impact_distance;
		logic             saturated;
	} result_beat_t;
endpackage
`default_nettype wire

>>> rtl/track_vertex_impact_parameter.sv
`timescale 1ns / 1ps
`default_nettype none
// Impact parameter of a straight track against a vertex: floor(256 * |d x v| / |v|) with
// d = track point - vertex and v = (slope_x, slope_y, 1.0), in 1/256 um, clamped to
// 2^33-1 with saturated set. Fully pipelined: one beat is taken every cycle while the output
// is not stalled. The restoring divider (one quotient bit per stage, 66 stages) forms
// 65536*C/V, followed by the digit-by-digit square root (one root bit per stage, 33 stages).
// In front of them sit six stages: input differences, slope products, cross product and
// |v|^2, split partial squares, their sum, and the range check. The whole pipe advances
// together; track_stall is high exactly when a finished result is held by result_stall.
`include "track_vertex_impact_parameter_macros.svh"
module track_vertex_impact_parameter
	import tvip_pkg::*;
#(
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   track_valid,
	output logic        track_stall,
	input  track_beat_t track,
	output logic        result_valid,
	input  wire logic   result_stall,
	output result_beat_t result
);
	localparam int F     = SLOPE_FRAC_BITS;
	localparam int DW    = POS_W + 1;                         // displacement
	localparam int PW    = DW + SLOPE_W;                      // slope product
	localparam int CW    = DW + ((F > SLOPE_W) ? F : SLOPE_W) + 1; // cross component
	localparam int MW    = CW;                                // magnitude
	localparam int HALF  = (MW + 1) / 2;
	localparam int LOW   = MW - HALF;
	localparam int CSW   = 2 * MW + 2;                        // |c|^2
	localparam int SQW   = 2 * SLOPE_W;                       // slope square
	localparam int VW    = ((2 * F + 1 > SQW - 1) ? 2 * F + 1 : SQW - 1) + 1;
	localparam int QW    = 2 * OUT_W;                         // quotient bits
	localparam int XW    = ((CSW + SCALE_SHIFT > VW + QW) ? CSW + SCALE_SHIFT : VW + QW) + 1;
	localparam int RW    = OUT_W + 3;                         // root remainder

	logic en;
	assign en          = !(result_valid && result_stall);
	assign track_stall = !en;

	// stage 1: displacement
	logic                      valid_s1;
	logic signed [SLOPE_W-1:0] sx_s1, sy_s1;
	logic signed [DW-1:0]      dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= track_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= track.slope_x;
			sy_s1 <= track.slope_y;
			dx_s1 <= DW'(track.track_x) - DW'(track.vertex_x);
			dy_s1 <= DW'(track.track_y) - DW'(track.vertex_y);
			dz_s1 <= DW'(track.track_z) - DW'(track.vertex_z);
		end
	end

	// stage 2: slope products
	logic                 valid_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic signed [PW-1:0] dzsy_s2, dxsy_s2, dysx_s2, dzsx_s2;
	logic signed [SQW-1:0] sxsq_s2, sysq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dzsy_s2 <= PW'(dz_s1) * PW'(sy_s1);
			dxsy_s2 <= PW'(dx_s1) * PW'(sy_s1);
			dysx_s2 <= PW'(dy_s1) * PW'(sx_s1);
			dzsx_s2 <= PW'(dz_s1) * PW'(sx_s1);
			sxsq_s2 <= SQW'(sx_s1) * SQW'(sx_s1);
			sysq_s2 <= SQW'(sy_s1) * SQW'(sy_s1);
		end
	end

	// stage 3: cross product magnitudes and |v|^2
	logic signed [CW-1:0] c0, c1, c2;
	logic        [VW-1:0] vsq;
	assign c0  = (CW'(dy_s2) <<< F) - CW'(dzsy_s2);
	assign c1  = CW'(dzsx_s2) - (CW'(dx_s2) <<< F);
	assign c2  = CW'(dxsy_s2) - CW'(dysx_s2);
	assign vsq = (VW'(1) << (2 * F)) + VW'(unsigned'(sxsq_s2)) + VW'(unsigned'(sysq_s2));

	logic          valid_s3;
	logic [MW-1:0] m0_s3, m1_s3, m2_s3;
	logic [VW-1:0] v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s3 <= c0[CW-1] ? MW'(-c0) : MW'(c0);
			m1_s3 <= c1[CW-1] ? MW'(-c1) : MW'(c1);
			m2_s3 <= c2[CW-1] ? MW'(-c2) : MW'(c2);
			v_s3  <= vsq;
		end
	end

	// stage 4: squares split into half-width partial products
	logic                     valid_s4;
	logic [2*HALF-1:0]        hh_s4 [3];
	logic [HALF+LOW-1:0]      hl_s4 [3];
	logic [2*LOW-1:0]         ll_s4 [3];
	logic [VW-1:0]            v_s4;
	logic [MW-1:0]            mag [3];
	assign mag[0] = m0_s3;
	assign mag[1] = m1_s3;
	assign mag[2] = m2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= (2*HALF)'(mag[i][MW-1:LOW]) * (2*HALF)'(mag[i][MW-1:LOW]);
				hl_s4[i] <= (HALF+LOW)'(mag[i][MW-1:LOW]) * (HALF+LOW)'(mag[i][LOW-1:0]);
				ll_s4[i] <= (2*LOW)'(mag[i][LOW-1:0]) * (2*LOW)'(mag[i][LOW-1:0]);
			end
			v_s4 <= v_s3;
		end
	end

	// stage 5: sum of squares
	logic [CSW-1:0] csum;
	always_comb begin
		csum = '0;
		for (int i = 0; i < 3; i++) begin
			csum = csum + (CSW'(hh_s4[i]) << (2 * LOW)) + (CSW'(hl_s4[i]) << (LOW + 1))
				+ CSW'(ll_s4[i]);
		end
	end

	logic           valid_s5;
	logic [CSW-1:0] c_s5;
	logic [VW-1:0]  v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= csum;
			v_s5 <= v_s4;
		end
	end

	// stage 6: range check and divider seed; the quotient fits QW bits unless saturated
	logic [XW-1:0] num_x, lim_x;
	assign num_x = XW'(c_s5) << SCALE_SHIFT;
	assign lim_x = XW'(v_s5) << QW;

	logic          dv_valid_s [0:QW];
	logic          dv_sat_s   [0:QW];
	logic [VW-1:0] dv_rem_s   [0:QW];
	logic [QW-1:0] dv_nq_s    [0:QW];
	logic [VW-1:0] dv_v_s     [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid_s[0] <= 1'b0;
		end else if (en) begin
			dv_valid_s[0] <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sat_s[0] <= (num_x >= lim_x);
			dv_rem_s[0] <= VW'(num_x >> QW);
			dv_nq_s[0]  <= num_x[QW-1:0];
			dv_v_s[0]   <= v_s5;
		end
	end

	// restoring divider: shift in one numerator bit, shift out one quotient bit
	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_div
			logic [VW:0] t;
			logic        ge;
			assign t  = {dv_rem_s[k], dv_nq_s[k][QW-1]};
			assign ge = (t >= {1'b0, dv_v_s[k]});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_valid_s[k+1] <= 1'b0;
				end else if (en) begin
					dv_valid_s[k+1] <= dv_valid_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_sat_s[k+1] <= dv_sat_s[k];
					dv_rem_s[k+1] <= ge ? VW'(t - {1'b0, dv_v_s[k]}) : t[VW-1:0];
					dv_nq_s[k+1]  <= {dv_nq_s[k][QW-2:0], ge};
					dv_v_s[k+1]   <= dv_v_s[k];
				end
			end
		end
	endgenerate

	// square root of the quotient, two radicand bits per stage
	logic             sq_valid_s [0:OUT_W];
	logic             sq_sat_s   [0:OUT_W];
	logic [RW-1:0]    sq_rem_s   [0:OUT_W];
	logic [OUT_W-1:0] sq_root_s  [0:OUT_W];
	logic [QW-1:0]    sq_rad_s   [0:OUT_W];

	assign sq_valid_s[0] = dv_valid_s[QW];
	assign sq_sat_s[0]   = dv_sat_s[QW];
	assign sq_rem_s[0]   = '0;
	assign sq_root_s[0]  = '0;
	assign sq_rad_s[0]   = dv_nq_s[QW];

	generate
		for (k = 0; k < OUT_W; k++) begin : g_sqrt
			logic [RW-1:0] t, trial;
			logic          ge;
			assign t     = {sq_rem_s[k][RW-3:0], sq_rad_s[k][QW-1:QW-2]};
			assign trial = RW'({sq_root_s[k], 2'b01});
			assign ge    = (t >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_valid_s[k+1] <= 1'b0;
				end else if (en) begin
					sq_valid_s[k+1] <= sq_valid_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_sat_s[k+1]  <= sq_sat_s[k];
					sq_rem_s[k+1]  <= ge ? (t - trial) : t;
					sq_root_s[k+1] <= {sq_root_s[k][OUT_W-2:0], ge};
					sq_rad_s[k+1]  <= {sq_rad_s[k][QW-3:0], 2'b00};
				end
			end
		end
	endgenerate

	// output register: clamp on saturation, hold while the sink stalls
	logic         out_valid_q;
	result_beat_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_valid_s[OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.impact_distance <= sq_sat_s[OUT_W] ? '1 : sq_root_s[OUT_W];
			out_q.saturated       <= sq_sat_s[OUT_W];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`TVIP_ASSERT_NOW(a_stall_follows_sink, 1'b1, track_stall == (result_valid && result_stall))
	`TVIP_ASSERT_NOW(a_sat_clamps, result_valid && result.saturated, &result.impact_distance)
	`TVIP_ASSERT_NEXT(a_held_result, result_valid && result_stall, result_valid)
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import tvip_pkg::*;

	localparam int FRAC_BITS     = 16;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int HOLD_CYCLES   = 400;
	// The pipe is 106 deep; a full hold-off plus a drain fits well inside this.
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 150;

	// Exact impact parameter model plus the queue of expected result beats.
	class impact_scoreboard;
		result_beat_t expected_q[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		// floor(256*|d x v|/|v|) as the largest q with q*q*V <= 65536*C, saturating.
		function result_beat_t compute_impact(track_beat_t b);
			longint sx, sy, dx, dy, dz, one, c0, c1, c2;
			logic [63:0] u0, u1, u2;
			logic [255:0] csq, vsq, target, limit, cand, q;
			result_beat_t r;
			sx = b.slope_x;
			sy = b.slope_y;
			dx = longint'(b.track_x) - longint'(b.vertex_x);
			dy = longint'(b.track_y) - longint'(b.vertex_y);
			dz = longint'(b.track_z) - longint'(b.vertex_z);
			one = longint'(1) <<< FRAC_BITS;
			c0 = dy * one - dz * sy;
			c1 = dz * sx - dx * one;
			c2 = dx * sy - dy * sx;
			u0 = (c0 < 0) ? -c0 : c0;
			u1 = (c1 < 0) ? -c1 : c1;
			u2 = (c2 < 0) ? -c2 : c2;
			csq = {192'b0, u0} * {192'b0, u0} + {192'b0, u1} * {192'b0, u1}
				+ {192'b0, u2} * {192'b0, u2};
			vsq = (256'd1 << (2 * FRAC_BITS)) + 256'(sx * sx) + 256'(sy * sy);
			target = csq << SCALE_SHIFT;
			limit = vsq << (2 * OUT_W);
			if (limit <= target) begin
				r.impact_distance = '1;
				r.saturated = 1'b1;
				return r;
			end
			q = '0;
			for (int i = OUT_W - 1; i >= 0; i--) begin
				cand = q | (256'd1 << i);
				if (cand * cand * vsq <= target)
					q = cand;
			end
			r.impact_distance = q[OUT_W-1:0];
			r.saturated = 1'b0;
			return r;
		endfunction

		function void note_track(track_beat_t b);
			expected_q.push_back(compute_impact(b));
		endfunction

		function void check_result(result_beat_t got);
			result_beat_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: distance %0d sat %0b",
						got.impact_distance, got.saturated);
				return;
			end
			want = expected_q.pop_front();
			if (got.impact_distance !== want.impact_distance ||
					got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: distance exp %0d got %0d, sat exp %0b got %0b",
						want.impact_distance, got.impact_distance,
						want.saturated, got.saturated);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         track_valid;
	logic         track_stall;
	track_beat_t  track;
	logic         result_valid;
	logic         result_stall;
	result_beat_t result;

	impact_scoreboard sb = new();
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  quiet_cycles;

	track_vertex_impact_parameter #(.SLOPE_FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.track_valid(track_valid),
		.track_stall(track_stall),
		.track(track),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample both channels at the edge; every check works on pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (track_valid && !track_stall)
				sb.note_track(track);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// Watchdog: count cycles with no beat moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (track_valid && !track_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Receiver: random stall, or one long hold-off on request so the pipe backs up.
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Offer one beat, with random idle cycles ahead of it; return at its accepting edge.
	task automatic drive_track(track_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			track_valid <= 1'b0;
			@(posedge clk);
		end
		track <= b;
		track_valid <= 1'b1;
		@(posedge clk);
		while (track_stall)
			@(posedge clk);
	endtask

	function automatic track_beat_t make_track(int sx, int sy, int tx, int ty, int tz,
			int vx, int vy, int vz);
		track_beat_t b;
		b.slope_x = sx;
		b.slope_y = sy;
		b.track_x = tx;
		b.track_y = ty;
		b.track_z = tz;
		b.vertex_x = vx;
		b.vertex_y = vy;
		b.vertex_z = vz;
		return b;
	endfunction

	// Mix of fully random fields, detector-sized geometry, and vertices near the line.
	function automatic track_beat_t random_track();
		track_beat_t b;
		int k;
		b = make_track($urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		case ($urandom_range(0, 3))
			0: ; // full range, saturates often
			1: begin
				b.slope_x = $urandom_range(0, 262144) - 131072;
				b.slope_y = $urandom_range(0, 262144) - 131072;
				b.vertex_x = b.track_x + $urandom_range(0, 10000) - 5000;
				b.vertex_y = b.track_y + $urandom_range(0, 10000) - 5000;
				b.vertex_z = b.track_z + $urandom_range(0, 200000) - 100000;
			end
			default: begin
				// step k along the line from the track point, then nudge a little
				k = $urandom_range(0, 2000) - 1000;
				b.slope_x = $urandom_range(0, 8) * 16384 - 65536;
				b.slope_y = $urandom_range(0, 8) * 16384 - 65536;
				b.track_x = $urandom_range(0, 2000000) - 1000000;
				b.track_y = $urandom_range(0, 2000000) - 1000000;
				b.track_z = $urandom_range(0, 2000000) - 1000000;
				b.vertex_x = b.track_x + int'((k * int'(b.slope_x)) >>> FRAC_BITS)
					+ $urandom_range(0, 4) - 2;
				b.vertex_y = b.track_y + int'((k * int'(b.slope_y)) >>> FRAC_BITS)
					+ $urandom_range(0, 4) - 2;
				b.vertex_z = b.track_z + k;
			end
		endcase
		return b;
	endfunction

	localparam int SMAX = 524287;
	localparam int SMIN = -524288;
	localparam int PMAX = 8388607;
	localparam int PMIN = -8388608;

	initial begin
		track_beat_t directed[$];
		arst_n = 1'b0;
		track_valid <= 1'b0;
		track <= '0;
		hold_req = 1'b0;
		send_idle_pct = 6;
		recv_stall_pct = 60;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: vertex on the line, zero slopes, extremes and saturation
		directed.push_back(make_track(0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_track(0, 0, 1, 0, 0, 0, 0, 0));
		directed.push_back(make_track(0, 0, 0, 0, 5000, 0, 0, 0));
		directed.push_back(make_track(65536, 0, 10, 20, 30, 110, 20, 130));
		directed.push_back(make_track(65536, -65536, 0, 0, 0, 7, -7, 7));
		directed.push_back(make_track(SMAX, SMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
		directed.push_back(make_track(SMIN, SMIN, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
		directed.push_back(make_track(SMAX, SMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN));
		directed.push_back(make_track(0, 0, PMAX, PMAX, 0, PMIN, PMIN, 0));
		directed.push_back(make_track(0, 0, PMAX, 0, 0, PMIN, 0, 0));
		directed.push_back(make_track(SMAX, SMAX, PMAX, PMIN, 0, PMIN, PMAX, 0));
		directed.push_back(make_track(SMIN, 0, 0, 0, PMAX, 0, 0, PMIN));
		directed.push_back(make_track(-1, -1, -1, -1, -1, -1, -1, -1));
		directed.push_back(make_track(1, 1, 1, 1, 1, 0, 0, 0));
		directed.push_back(make_track(SMAX, 0, 0, 0, 0, 0, 0, 1));
		directed.push_back(make_track(0, SMIN, 0, 0, 0, 0, 0, 1));
		directed.push_back(make_track(12345, -54321, 1000, -2000, 3000, -4000, 5000, -6000));
		directed.push_back(make_track(0, 0, 8388607, -8388608, 0, 0, 0, 0));
		foreach (directed[i])
			drive_track(directed[i]);

		// three idling phases; the last one also backs the pipe up once
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 60 : 0;
			recv_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 6 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 2 && n == 40)
					hold_req = 1'b1;
				drive_track(random_track());
			end
		end
		track_valid <= 1'b0;

		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

>>> track_vertex_impact_parameter.f
+incdir+rtl
rtl/tvip_pkg.sv
rtl/track_vertex_impact_parameter.sv
verif/tb.sv
